// ===== design/websocket_frame_deframer_top_defines.svh =====
// Assertion helpers used by the checker file of the deframer (wsfd_checker).
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while in reset.
`define WSFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while in reset.
`define WSFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/wsfd_pkg.sv =====
package wsfd_pkg;

    // Sizes and reset values
    localparam int INDEX_BITS_DEF = 21;
    localparam int MP_BITS        = 21;
    localparam logic [MP_BITS-1:0] MAX_PAYLOAD_RESET = 21'd524288;
    localparam int FIFO_DEPTH     = 4;

    // Result event codes
    typedef enum logic [2:0] {
        EV_DATA    = 3'd0,
        EV_PING    = 3'd1,
        EV_ABANDON = 3'd2,
        EV_CLOSE   = 3'd3,
        EV_ERROR   = 3'd4
    } ev_t;

    // Header parse phases
    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_MASK,
        PH_PAY,
        PH_ERR
    } phase_t;

    // Frame opcodes
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    // Length escapes and header byte counts
    localparam logic [6:0] LEN_EXT16  = 7'd126;
    localparam logic [6:0] LEN_EXT64  = 7'd127;
    localparam logic [3:0] HCNT_EXT16 = 4'd2;
    localparam logic [3:0] HCNT_EXT64 = 4'd8;
    localparam logic [3:0] HCNT_MASK  = 4'd4;

    // One result beat
    typedef struct packed {
        ev_t        ev;
        logic [7:0] data;
        logic       has_data;
        logic       binary;
        logic       last;
    } res_t;

endpackage

// ===== design/wsfd_parser.sv =====
module wsfd_parser
    import wsfd_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    input  logic [7:0]         rx_byte,
    input  logic [MP_BITS-1:0] max_payload,
    output logic [1:0]         res_n,
    output res_t               res_a,
    output res_t               res_b
);

    localparam int CW = (INDEX_BITS > MP_BITS) ? INDEX_BITS : MP_BITS;

    phase_t                  phase_reg, phase_next;
    logic [3:0]              hcnt_reg, hcnt_next;
    logic [3:0]              opcode_reg, opcode_next;
    logic                    fin_reg, fin_next;
    logic                    masked_reg, masked_next;
    logic [INDEX_BITS-1:0]   len_reg, len_next;
    logic                    ovf_reg, ovf_next;
    logic [INDEX_BITS-1:0]   idx_reg, idx_next;
    logic [31:0]             mask_reg, mask_next;
    logic                    msg_bin_reg, msg_bin_next;
    logic                    msg_frag_reg, msg_frag_next;

    logic [6:0]              len7;
    logic                    is_ext;
    logic [INDEX_BITS+7:0]   len_wide;
    logic [INDEX_BITS-1:0]   len_shift;
    logic                    ovf_shift;
    logic [INDEX_BITS-1:0]   len_chk;
    logic                    ovf_chk;
    logic                    oversize;
    logic                    len_zero;
    logic                    hdr_done;
    phase_t                  hdr_phase;
    logic [INDEX_BITS-1:0]   idx_inc;
    logic                    pay_end;
    logic [7:0]              mask_byte;
    logic [7:0]              plain;
    res_t                    c1, c2;
    logic                    v1, v2;

    // Length field decode
    assign len7      = rx_byte[6:0];
    assign is_ext    = (len7 == LEN_EXT16) || (len7 == LEN_EXT64);
    assign len_wide  = {len_reg, rx_byte};
    assign len_shift = len_wide[INDEX_BITS-1:0];
    assign ovf_shift = ovf_reg | (|len_wide[INDEX_BITS+7:INDEX_BITS]);

    // Pick the final frame length at the byte that completes the header
    always_comb
    begin
        unique case (phase_reg)
            PH_HDR1:
            begin
                len_chk = INDEX_BITS'(len7);
                ovf_chk = 1'b0;
            end
            PH_EXT:
            begin
                len_chk = len_shift;
                ovf_chk = ovf_shift;
            end
            default:
            begin
                len_chk = len_reg;
                ovf_chk = ovf_reg;
            end
        endcase
    end

    assign oversize = ovf_chk || (CW'(len_chk) > CW'(max_payload));
    assign len_zero = (len_chk == '0);
    assign hdr_done = byte_valid &&
                      (((phase_reg == PH_HDR1) && !is_ext && !rx_byte[7]) ||
                       ((phase_reg == PH_EXT) && (hcnt_reg == 4'd1) && !masked_reg) ||
                       ((phase_reg == PH_MASK) && (hcnt_reg == 4'd1)));
    assign hdr_phase = oversize ? PH_ERR : (len_zero ? PH_HDR0 : PH_PAY);

    // Payload position and unmask
    assign idx_inc = idx_reg + INDEX_BITS'(1);
    assign pay_end = (idx_inc == len_reg);

    always_comb
    begin
        unique case (idx_reg[1:0])
            2'd0:    mask_byte = mask_reg[31:24];
            2'd1:    mask_byte = mask_reg[23:16];
            2'd2:    mask_byte = mask_reg[15:8];
            default: mask_byte = mask_reg[7:0];
        endcase
    end

    assign plain = rx_byte ^ mask_byte;

    // Next parse phase
    always_comb
    begin
        phase_next = phase_reg;
        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_HDR0: phase_next = PH_HDR1;
                PH_HDR1:
                begin
                    if (is_ext)
                        phase_next = PH_EXT;
                    else if (rx_byte[7])
                        phase_next = PH_MASK;
                    else
                        phase_next = hdr_phase;
                end
                PH_EXT:
                begin
                    if (hcnt_reg == 4'd1)
                        phase_next = masked_reg ? PH_MASK : hdr_phase;
                end
                PH_MASK:
                begin
                    if (hcnt_reg == 4'd1)
                        phase_next = hdr_phase;
                end
                PH_PAY:  phase_next = pay_end ? PH_HDR0 : PH_PAY;
                PH_ERR:  phase_next = PH_ERR;
                default: phase_next = PH_HDR0;
            endcase
        end
    end

    // Header fields, payload position and results
    always_comb
    begin
        hcnt_next     = hcnt_reg;
        opcode_next   = opcode_reg;
        fin_next      = fin_reg;
        masked_next   = masked_reg;
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        idx_next      = idx_reg;
        mask_next     = mask_reg;
        msg_bin_next  = msg_bin_reg;
        msg_frag_next = msg_frag_reg;
        c1 = '{ev: EV_DATA, data: 8'd0, has_data: 1'b0, binary: 1'b0, last: 1'b0};
        c2 = '{ev: EV_DATA, data: 8'd0, has_data: 1'b0, binary: 1'b0, last: 1'b0};
        v1 = 1'b0;
        v2 = 1'b0;

        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    fin_next    = rx_byte[7];
                    opcode_next = rx_byte[3:0];
                    len_next    = '0;
                    ovf_next    = 1'b0;
                    mask_next   = '0;
                end
                PH_HDR1:
                begin
                    masked_next = rx_byte[7];
                    if (len7 == LEN_EXT16)
                        hcnt_next = HCNT_EXT16;
                    else if (len7 == LEN_EXT64)
                        hcnt_next = HCNT_EXT64;
                    else
                    begin
                        len_next = INDEX_BITS'(len7);
                        if (rx_byte[7])
                            hcnt_next = HCNT_MASK;
                    end
                end
                PH_EXT:
                begin
                    len_next = len_shift;
                    ovf_next = ovf_shift;
                    if ((hcnt_reg == 4'd1) && masked_reg)
                        hcnt_next = HCNT_MASK;
                    else
                        hcnt_next = hcnt_reg - 4'd1;
                end
                PH_MASK:
                begin
                    mask_next = {mask_reg[23:0], rx_byte};
                    hcnt_next = hcnt_reg - 4'd1;
                end
                PH_PAY:
                begin
                    idx_next = idx_inc;
                    if ((opcode_reg == OP_CONT) || (opcode_reg == OP_TEXT) ||
                        (opcode_reg == OP_BIN))
                    begin
                        v1 = 1'b1;
                        c1 = '{ev: EV_DATA, data: plain, has_data: 1'b1,
                               binary: msg_bin_reg, last: pay_end && fin_reg};
                    end
                    else if (opcode_reg == OP_PING)
                    begin
                        v1 = 1'b1;
                        c1 = '{ev: EV_PING, data: plain, has_data: 1'b1,
                               binary: 1'b0, last: pay_end};
                    end
                end
                default: ;
            endcase

            // Header complete: size check and frame-start events
            if (hdr_done)
            begin
                if (oversize)
                begin
                    v1 = 1'b1;
                    c1 = '{ev: EV_ERROR, data: 8'd0, has_data: 1'b0,
                           binary: 1'b0, last: 1'b0};
                end
                else
                begin
                    idx_next = '0;
                    unique case (opcode_reg)
                        OP_TEXT, OP_BIN:
                        begin
                            if (msg_frag_reg)
                            begin
                                v1 = 1'b1;
                                c1 = '{ev: EV_ABANDON, data: 8'd0, has_data: 1'b0,
                                       binary: msg_bin_reg, last: 1'b0};
                            end
                            msg_bin_next  = (opcode_reg == OP_BIN);
                            msg_frag_next = !fin_reg;
                            if (len_zero && fin_reg)
                            begin
                                v2 = 1'b1;
                                c2 = '{ev: EV_DATA, data: 8'd0, has_data: 1'b0,
                                       binary: (opcode_reg == OP_BIN), last: 1'b1};
                            end
                        end
                        OP_CONT:
                        begin
                            if (fin_reg)
                            begin
                                msg_frag_next = 1'b0;
                                if (len_zero)
                                begin
                                    v2 = 1'b1;
                                    c2 = '{ev: EV_DATA, data: 8'd0, has_data: 1'b0,
                                           binary: msg_bin_reg, last: 1'b1};
                                end
                            end
                        end
                        OP_CLOSE:
                        begin
                            v2 = 1'b1;
                            c2 = '{ev: EV_CLOSE, data: 8'd0, has_data: 1'b0,
                                   binary: 1'b0, last: 1'b0};
                        end
                        OP_PING:
                        begin
                            if (len_zero)
                            begin
                                v2 = 1'b1;
                                c2 = '{ev: EV_PING, data: 8'd0, has_data: 1'b0,
                                       binary: 1'b0, last: 1'b1};
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end

        res_a = v1 ? c1 : c2;
        res_b = c2;
        res_n = {1'b0, v1} + {1'b0, v2};
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            hcnt_reg     <= '0;
            opcode_reg   <= '0;
            fin_reg      <= 1'b0;
            masked_reg   <= 1'b0;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            idx_reg      <= '0;
            mask_reg     <= '0;
            msg_bin_reg  <= 1'b0;
            msg_frag_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hcnt_reg     <= hcnt_next;
            opcode_reg   <= opcode_next;
            fin_reg      <= fin_next;
            masked_reg   <= masked_next;
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
            idx_reg      <= idx_next;
            mask_reg     <= mask_next;
            msg_bin_reg  <= msg_bin_next;
            msg_frag_reg <= msg_frag_next;
        end
    end

endmodule

// ===== design/wsfd_fifo.sv =====
module wsfd_fifo
    import wsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_n,
    input  res_t       push_a,
    input  res_t       push_b,
    input  logic       pop,
    output logic       has_room,
    output logic       not_empty,
    output res_t       head
);

    localparam int PW = $clog2(FIFO_DEPTH);

    res_t          mem_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic [PW-1:0] wr_ptr_b;

    // Room for the two beats a single byte may produce
    assign has_room  = (count_reg <= (PW+1)'(FIFO_DEPTH - 2));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign wr_ptr_b  = wr_ptr_reg + PW'(1);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push_n);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + (PW+1)'(push_n) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store up to two beats
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem_reg[wr_ptr_reg] <= push_a;
        if (push_n == 2'd2)
            mem_reg[wr_ptr_b] <= push_b;
    end

endmodule

// ===== design/websocket_frame_deframer_top.sv =====
// WebSocket receive deframer: takes one link byte per beat on rx_byte, parses the frame
// header (FIN, opcode, 7/16/64-bit length, optional mask key) and returns unmasked text,
// binary and ping payload bytes plus abandon, close and oversize events. Each byte is
// handled in the cycle it is accepted, so the input sustains one byte per clock while the
// output side takes a beat every cycle. Results pass through a 4-entry queue; in_ready
// drops when fewer than two entries are free, so a header byte that yields two events
// (abandoned message followed by an empty final frame) always finds room for both. A
// length above max_payload raises one oversize event, after which bytes are still taken
// but discarded until reset. The user must write max_payload (reset value 524288) through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce this.
module websocket_frame_deframer_top
    import wsfd_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [MP_BITS-1:0] cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         event_res,
    output logic [7:0]         data,
    output logic               has_data,
    output logic               binary,
    output logic               last
);

    logic [MP_BITS-1:0] max_payload_reg;
    logic               accept;
    logic [1:0]         res_n;
    res_t               res_a, res_b;
    res_t               head;

    // Hold the size limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_payload_reg <= MAX_PAYLOAD_RESET;
        else if (cfg_wr_en)
            max_payload_reg <= cfg_wr_data;
    end

    assign accept = in_valid && in_ready;

    wsfd_parser #(
        .INDEX_BITS (INDEX_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (accept),
        .rx_byte     (rx_byte),
        .max_payload (max_payload_reg),
        .res_n       (res_n),
        .res_a       (res_a),
        .res_b       (res_b)
    );

    wsfd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (res_n),
        .push_a    (res_a),
        .push_b    (res_b),
        .pop       (out_valid && out_ready),
        .has_room  (in_ready),
        .not_empty (out_valid),
        .head      (head)
    );

    // Drive the result beat
    assign event_res = head.ev;
    assign data      = head.data;
    assign has_data  = head.has_data;
    assign binary    = head.binary;
    assign last      = head.last;

endmodule

// ===== design/wsfd_checker.sv =====
`include "websocket_frame_deframer_top_defines.svh"

module wsfd_checker
    import wsfd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] event_res,
    input logic [7:0] data,
    input logic       has_data,
    input logic       binary,
    input logic       last
);

    // A stalled result beat holds its payload
    `WSFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(event_res) && $stable(data) && $stable(has_data) &&
        $stable(binary) && $stable(last), "stalled result changed")

    // Marker-only events carry no byte and no end mark
    `WSFD_ASSERT_NOW(a_marker_plain, out_valid &&
        (event_res == EV_ABANDON || event_res == EV_CLOSE || event_res == EV_ERROR),
        !has_data && !last, "event beat carries data or last")

    // Type mark only on message events
    `WSFD_ASSERT_NOW(a_binary_scope, out_valid && binary,
        event_res == EV_DATA || event_res == EV_ABANDON, "binary mark on non-message event")

    // Marker beats carry a zero byte
    `WSFD_ASSERT_NOW(a_marker_zero, out_valid && !has_data,
        data == 8'd0, "marker beat with nonzero data")

    // Oversize error is the final result until reset
    `WSFD_ASSERT_NEXT(a_error_final, out_valid && out_ready && event_res == EV_ERROR,
        !out_valid, "result after oversize error")

endmodule

bind websocket_frame_deframer_top wsfd_checker u_wsfd_checker (.*);
